### rtl/lrfc_pkg.sv
package lrfc_pkg;

    // Sizes of the two stores
    parameter int FRAME_BYTES = 16;
    parameter int LEVEL_SLOTS = 8;
    parameter int FS_AW       = $clog2(FRAME_BYTES);
    parameter int SLOT_AW     = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;
    parameter int COUNT_MAX   = 31;
    parameter int CNT_W       = $clog2(COUNT_MAX + 1);

    // Field and register widths
    parameter int OPCODE_W    = 3;
    parameter int BYTE_W      = 8;
    parameter int SLOT_IDX_W  = 4;
    parameter int MODE_W      = 3;
    parameter int SEND_W      = 2;
    parameter int STATUS_W    = 3;
    parameter int DIST_W      = 32;
    parameter int LEVEL_W     = 16;
    parameter int RELOAD_W    = 15;
    parameter int BUDGET_W    = 16;
    parameter int CFG_IDX_W   = 1;
    parameter int CFG_DATA_W  = 32;

    // Frame layout
    parameter logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;
    parameter logic [BYTE_W-1:0] CMD_BYTE = 8'h22;
    parameter int HDR_POS     = 0;
    parameter int CMD_POS     = 3;
    parameter int DIST_POS    = 6;

    // Reset values
    parameter logic [DIST_W-1:0]   MAX_DIST_RESET = 32'd4000;
    parameter logic [RELOAD_W-1:0] RELOAD_RESET   = 15'd10;
    parameter logic [BUDGET_W-1:0] BUDGET_RESET   = 16'd10;

    // Configuration register indexes
    parameter logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'd0;
    parameter logic [CFG_IDX_W-1:0] REG_RELOAD   = 1'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RX_BYTE   = 3'd0,
        OP_POLL      = 3'd1,
        OP_POWER_ON  = 3'd2,
        OP_READ_LVL  = 3'd3,
        OP_POWER_OFF = 3'd4,
        OP_READ_SLOT = 3'd5
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 3'd0,
        MODE_ON    = 3'd1,
        MODE_OFF   = 3'd2,
        MODE_READ  = 3'd3,
        MODE_DONE  = 3'd4,
        MODE_ABORT = 3'd5
    } t_mode;

    typedef enum logic [SEND_W-1:0] {
        SEND_NONE     = 2'd0,
        SEND_POWER_ON = 2'd1,
        SEND_GET_DIST = 2'd2
    } t_send;

    typedef enum logic [STATUS_W-1:0] {
        ST_NO_FRAME = 3'd0,
        ST_OK       = 3'd1,
        ST_BAD_HDR  = 3'd2,
        ST_NO_SYNC  = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_HEAD,
        S_SYNC,
        S_SEARCH,
        S_GATHER,
        S_RANGE,
        S_SCAN,
        S_FIN
    } t_ctrl_state;

    // Datapath commands issued by the sequencer
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_HEAD,
        DP_SYNC,
        DP_SEARCH,
        DP_GATHER,
        DP_RANGE,
        DP_SCAN,
        DP_FIN
    } t_dp_op;

    typedef struct packed {
        logic pending;
        logic mode_done;
        logic mode_read;
        logic hdr_match;
        logic cmd_match;
        logic search_end;
        logic gather_last;
        logic in_range;
        logic slot_empty;
        logic scan_last;
    } t_dp_sts;

endpackage

### rtl/lrfc_ctrl.sv
module lrfc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [lrfc_pkg::OPCODE_W-1:0] i_opcode,
    input  lrfc_pkg::t_dp_sts             i_sts,
    output lrfc_pkg::t_dp_op              o_op,
    output logic                          busy
);

    lrfc_pkg::t_ctrl_state r_state;
    lrfc_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrfc_pkg::S_IDLE: begin
                if (start && (i_opcode == lrfc_pkg::OP_POLL)) begin
                    n_state = lrfc_pkg::S_CHECK;
                end
            end
            lrfc_pkg::S_CHECK: begin
                if (i_sts.mode_done || !i_sts.pending) begin
                    n_state = lrfc_pkg::S_FIN;
                end else begin
                    n_state = lrfc_pkg::S_HEAD;
                end
            end
            lrfc_pkg::S_HEAD: begin
                if (i_sts.hdr_match && i_sts.mode_read) begin
                    n_state = lrfc_pkg::S_SYNC;
                end else begin
                    n_state = lrfc_pkg::S_FIN;
                end
            end
            lrfc_pkg::S_SYNC: begin
                if (i_sts.cmd_match) begin
                    n_state = lrfc_pkg::S_GATHER;
                end else begin
                    n_state = lrfc_pkg::S_SEARCH;
                end
            end
            lrfc_pkg::S_SEARCH: begin
                if (i_sts.search_end) begin
                    n_state = lrfc_pkg::S_FIN;
                end else if (i_sts.hdr_match) begin
                    n_state = lrfc_pkg::S_GATHER;
                end
            end
            lrfc_pkg::S_GATHER: begin
                if (i_sts.gather_last) begin
                    n_state = lrfc_pkg::S_RANGE;
                end
            end
            lrfc_pkg::S_RANGE: begin
                if (i_sts.in_range) begin
                    n_state = lrfc_pkg::S_SCAN;
                end else begin
                    n_state = lrfc_pkg::S_FIN;
                end
            end
            lrfc_pkg::S_SCAN: begin
                if (i_sts.slot_empty || i_sts.scan_last) begin
                    n_state = lrfc_pkg::S_FIN;
                end
            end
            lrfc_pkg::S_FIN: begin
                n_state = lrfc_pkg::S_IDLE;
            end
            default: begin
                n_state = lrfc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        busy = 1'b1;
        o_op = lrfc_pkg::DP_NOP;
        unique case (r_state)
            lrfc_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_op = lrfc_pkg::DP_ACCEPT;
                end
            end
            lrfc_pkg::S_CHECK:  o_op = lrfc_pkg::DP_NOP;
            lrfc_pkg::S_HEAD:   o_op = lrfc_pkg::DP_HEAD;
            lrfc_pkg::S_SYNC:   o_op = lrfc_pkg::DP_SYNC;
            lrfc_pkg::S_SEARCH: o_op = lrfc_pkg::DP_SEARCH;
            lrfc_pkg::S_GATHER: o_op = lrfc_pkg::DP_GATHER;
            lrfc_pkg::S_RANGE:  o_op = lrfc_pkg::DP_RANGE;
            lrfc_pkg::S_SCAN:   o_op = lrfc_pkg::DP_SCAN;
            lrfc_pkg::S_FIN:    o_op = lrfc_pkg::DP_FIN;
            default:            o_op = lrfc_pkg::DP_NOP;
        endcase
    end

endmodule

### rtl/lrfc_dp.sv
module lrfc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lrfc_pkg::t_dp_op                i_op,
    output lrfc_pkg::t_dp_sts               o_sts,
    input  logic                            i_cfg_we,
    input  logic [lrfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lrfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [lrfc_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [lrfc_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic [lrfc_pkg::SLOT_IDX_W-1:0] i_slot_index,
    output logic                            o_valid,
    output logic [lrfc_pkg::MODE_W-1:0]     o_mode,
    output logic [lrfc_pkg::SEND_W-1:0]     o_send_command,
    output logic [lrfc_pkg::STATUS_W-1:0]   o_parse_status,
    output logic [lrfc_pkg::DIST_W-1:0]     o_distance_value,
    output logic                            o_slot_written,
    output logic [lrfc_pkg::SLOT_IDX_W-1:0] o_slot_number,
    output logic [lrfc_pkg::LEVEL_W-1:0]    o_level_value
);

    // Configuration
    logic [lrfc_pkg::DIST_W-1:0]   r_max;
    logic [lrfc_pkg::RELOAD_W-1:0] r_reload;

    // Block state
    lrfc_pkg::t_mode               r_mode,    n_mode;
    logic signed [lrfc_pkg::BUDGET_W-1:0] r_budget, n_budget;
    logic                          r_pending, n_pending;
    logic [lrfc_pkg::BYTE_W-1:0]   r_fs [lrfc_pkg::FRAME_BYTES];
    logic [lrfc_pkg::BYTE_W-1:0]   n_fs [lrfc_pkg::FRAME_BYTES];
    logic [lrfc_pkg::CNT_W-1:0]    r_count,   n_count;
    logic [lrfc_pkg::LEVEL_W-1:0]  r_slots [lrfc_pkg::LEVEL_SLOTS];
    logic [lrfc_pkg::LEVEL_W-1:0]  n_slots [lrfc_pkg::LEVEL_SLOTS];
    logic [lrfc_pkg::DIST_W-1:0]   r_dist,    n_dist;

    // Walk state
    logic [lrfc_pkg::CNT_W-1:0]    r_idx,     n_idx;
    logic [lrfc_pkg::FS_AW-1:0]    r_at,      n_at;

    // Result registers
    logic                          r_valid,   n_valid;
    lrfc_pkg::t_send               r_send,    n_send;
    lrfc_pkg::t_status             r_status,  n_status;
    logic                          r_wrote,   n_wrote;
    logic [lrfc_pkg::SLOT_IDX_W-1:0] r_slot_no, n_slot_no;
    logic [lrfc_pkg::LEVEL_W-1:0]  r_level,   n_level;

    // Read ports
    logic [lrfc_pkg::CNT_W-1:0]    n_bytes;
    logic [lrfc_pkg::CNT_W-1:0]    g_sum;
    logic [lrfc_pkg::CNT_W-1:0]    g_base;
    logic [lrfc_pkg::FS_AW-1:0]    fs_addr;
    logic [lrfc_pkg::BYTE_W-1:0]   fs_rd;
    logic [lrfc_pkg::SLOT_AW-1:0]  slot_addr;
    logic [lrfc_pkg::LEVEL_W-1:0]  slot_rd;
    logic [lrfc_pkg::CNT_W-1:0]    base_cnt;

    assign n_bytes = (r_count >= lrfc_pkg::CNT_W'(lrfc_pkg::FRAME_BYTES)) ?
                     lrfc_pkg::CNT_W'(lrfc_pkg::FRAME_BYTES) : r_count;

    // Byte of the distance field; after a resync it sits at offset r_at,
    // unless the shifted copy would have run past the batch.
    assign g_base = lrfc_pkg::CNT_W'(lrfc_pkg::DIST_POS) + lrfc_pkg::CNT_W'(r_idx[1:0]);
    assign g_sum  = g_base + lrfc_pkg::CNT_W'(r_at);

    always_comb begin
        case (i_op)
            lrfc_pkg::DP_HEAD:   fs_addr = lrfc_pkg::FS_AW'(lrfc_pkg::HDR_POS);
            lrfc_pkg::DP_SYNC:   fs_addr = lrfc_pkg::FS_AW'(lrfc_pkg::CMD_POS);
            lrfc_pkg::DP_SEARCH: fs_addr = r_idx[lrfc_pkg::FS_AW-1:0];
            lrfc_pkg::DP_GATHER: fs_addr = (g_sum < n_bytes) ?
                                           g_sum[lrfc_pkg::FS_AW-1:0] :
                                           g_base[lrfc_pkg::FS_AW-1:0];
            default:             fs_addr = '0;
        endcase
    end

    assign fs_rd     = r_fs[fs_addr];
    assign slot_addr = (i_op == lrfc_pkg::DP_ACCEPT) ?
                       i_slot_index[lrfc_pkg::SLOT_AW-1:0] :
                       r_idx[lrfc_pkg::SLOT_AW-1:0];
    assign slot_rd   = r_slots[slot_addr];
    assign base_cnt  = r_pending ? r_count : '0;

    always_comb begin
        o_sts.pending     = r_pending;
        o_sts.mode_done   = (r_mode == lrfc_pkg::MODE_DONE);
        o_sts.mode_read   = (r_mode == lrfc_pkg::MODE_READ);
        o_sts.hdr_match   = (fs_rd == lrfc_pkg::HDR_BYTE);
        o_sts.cmd_match   = (fs_rd == lrfc_pkg::CMD_BYTE);
        o_sts.search_end  = (r_idx >= n_bytes);
        o_sts.gather_last = (r_idx[1:0] == 2'd3);
        o_sts.in_range    = (r_dist <= r_max);
        o_sts.slot_empty  = (slot_rd == '0);
        o_sts.scan_last   = (r_idx[lrfc_pkg::SLOT_AW-1:0] ==
                             lrfc_pkg::SLOT_AW'(lrfc_pkg::LEVEL_SLOTS - 1));
    end

    always_comb begin
        n_mode    = r_mode;
        n_budget  = r_budget;
        n_pending = r_pending;
        n_fs      = r_fs;
        n_count   = r_count;
        n_slots   = r_slots;
        n_dist    = r_dist;
        n_idx     = r_idx;
        n_at      = r_at;
        n_valid   = 1'b0;
        n_send    = r_send;
        n_status  = r_status;
        n_wrote   = r_wrote;
        n_slot_no = r_slot_no;
        n_level   = r_level;

        case (i_op)
            lrfc_pkg::DP_ACCEPT: begin
                n_send    = lrfc_pkg::SEND_NONE;
                n_status  = lrfc_pkg::ST_NO_FRAME;
                n_wrote   = 1'b0;
                n_slot_no = '0;
                n_level   = '0;
                n_valid   = (i_opcode != lrfc_pkg::OP_POLL);
                unique case (i_opcode)
                    lrfc_pkg::OP_RX_BYTE: begin
                        // first byte of a batch clears the store
                        if (!r_pending) begin
                            for (int j = 0; j < lrfc_pkg::FRAME_BYTES; j++) begin
                                n_fs[j] = '0;
                            end
                        end
                        if (base_cnt < lrfc_pkg::CNT_W'(lrfc_pkg::FRAME_BYTES)) begin
                            n_fs[base_cnt[lrfc_pkg::FS_AW-1:0]] = i_rx_byte;
                        end
                        n_count   = (base_cnt < lrfc_pkg::CNT_W'(lrfc_pkg::COUNT_MAX)) ?
                                    base_cnt + lrfc_pkg::CNT_W'(1) : base_cnt;
                        n_pending = 1'b1;
                    end
                    lrfc_pkg::OP_POLL: begin
                        if (r_budget <= 0) begin
                            n_mode = lrfc_pkg::MODE_ABORT;
                        end
                    end
                    lrfc_pkg::OP_POWER_ON:  n_mode = lrfc_pkg::MODE_ON;
                    lrfc_pkg::OP_READ_LVL:  n_mode = lrfc_pkg::MODE_READ;
                    lrfc_pkg::OP_POWER_OFF: n_mode = lrfc_pkg::MODE_OFF;
                    lrfc_pkg::OP_READ_SLOT: begin
                        n_slot_no = i_slot_index;
                        if (lrfc_pkg::CNT_W'(i_slot_index) <
                            lrfc_pkg::CNT_W'(lrfc_pkg::LEVEL_SLOTS)) begin
                            n_level = slot_rd;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lrfc_pkg::DP_HEAD: begin
                n_pending = 1'b0;
                if (!o_sts.hdr_match) begin
                    n_status = lrfc_pkg::ST_BAD_HDR;
                end else if (!o_sts.mode_read) begin
                    n_status = lrfc_pkg::ST_OK;
                    if (r_mode == lrfc_pkg::MODE_ON) begin
                        n_budget = lrfc_pkg::BUDGET_W'(r_reload);
                        n_mode   = lrfc_pkg::MODE_DONE;
                    end
                end
            end
            lrfc_pkg::DP_SYNC: begin
                n_at  = '0;
                n_idx = o_sts.cmd_match ? lrfc_pkg::CNT_W'(0) : lrfc_pkg::CNT_W'(1);
            end
            lrfc_pkg::DP_SEARCH: begin
                if (o_sts.search_end) begin
                    n_status = lrfc_pkg::ST_NO_SYNC;
                end else if (o_sts.hdr_match) begin
                    n_at  = r_idx[lrfc_pkg::FS_AW-1:0];
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + lrfc_pkg::CNT_W'(1);
                end
            end
            lrfc_pkg::DP_GATHER: begin
                n_dist = {r_dist[lrfc_pkg::DIST_W-lrfc_pkg::BYTE_W-1:0], fs_rd};
                n_idx  = r_idx + lrfc_pkg::CNT_W'(1);
            end
            lrfc_pkg::DP_RANGE: begin
                n_idx = '0;
                if (!o_sts.in_range) begin
                    n_status = lrfc_pkg::ST_RANGE;
                end
            end
            lrfc_pkg::DP_SCAN: begin
                if (o_sts.slot_empty) begin
                    n_slots[r_idx[lrfc_pkg::SLOT_AW-1:0]] = r_dist[lrfc_pkg::LEVEL_W-1:0];
                    n_budget  = lrfc_pkg::BUDGET_W'(r_reload);
                    n_wrote   = 1'b1;
                    n_slot_no = lrfc_pkg::SLOT_IDX_W'(r_idx);
                    n_level   = r_dist[lrfc_pkg::LEVEL_W-1:0];
                    n_status  = lrfc_pkg::ST_OK;
                end else if (o_sts.scan_last) begin
                    n_mode   = lrfc_pkg::MODE_DONE;
                    n_budget = lrfc_pkg::BUDGET_W'(r_reload);
                    n_status = lrfc_pkg::ST_OK;
                end else begin
                    n_idx = r_idx + lrfc_pkg::CNT_W'(1);
                end
            end
            lrfc_pkg::DP_FIN: begin
                n_valid = 1'b1;
                if (r_mode == lrfc_pkg::MODE_READ) begin
                    n_send   = lrfc_pkg::SEND_GET_DIST;
                    n_budget = r_budget - lrfc_pkg::BUDGET_W'(1);
                end else if (r_mode == lrfc_pkg::MODE_ON) begin
                    n_send   = lrfc_pkg::SEND_POWER_ON;
                    n_budget = r_budget - lrfc_pkg::BUDGET_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= lrfc_pkg::MAX_DIST_RESET;
            r_reload  <= lrfc_pkg::RELOAD_RESET;
            r_mode    <= lrfc_pkg::MODE_INIT;
            r_budget  <= lrfc_pkg::BUDGET_RESET;
            r_pending <= 1'b0;
            r_count   <= '0;
            r_dist    <= '0;
            r_valid   <= 1'b0;
            for (int j = 0; j < lrfc_pkg::LEVEL_SLOTS; j++) begin
                r_slots[j] <= '0;
            end
        end else begin
            if (i_cfg_we && (i_cfg_idx == lrfc_pkg::REG_MAX_DIST)) begin
                r_max <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == lrfc_pkg::REG_RELOAD)) begin
                r_reload <= i_cfg_data[lrfc_pkg::RELOAD_W-1:0];
            end
            r_mode    <= n_mode;
            r_budget  <= n_budget;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_dist    <= n_dist;
            r_valid   <= n_valid;
            r_slots   <= n_slots;
        end
    end

    // Payload; the frame store is cleared by the first byte of every batch
    always_ff @(posedge i_clk) begin
        r_fs      <= n_fs;
        r_idx     <= n_idx;
        r_at      <= n_at;
        r_send    <= n_send;
        r_status  <= n_status;
        r_wrote   <= n_wrote;
        r_slot_no <= n_slot_no;
        r_level   <= n_level;
    end

    assign o_valid          = r_valid;
    assign o_mode           = r_mode;
    assign o_send_command   = r_send;
    assign o_parse_status   = r_status;
    assign o_distance_value = r_dist;
    assign o_slot_written   = r_wrote;
    assign o_slot_number    = r_slot_no;
    assign o_level_value    = r_level;

endmodule

### rtl/laser_range_frame_collector_core.sv
// Channel   Handshake               Payload
// -------   ---------------------   ------------------------------------------
// request   start & !busy           i_opcode, i_rx_byte, i_slot_index
// result    o_valid (1 cycle)       o_mode, o_send_command, o_parse_status,
//                                   o_distance_value, o_slot_written,
//                                   o_slot_number, o_level_value
// config    i_cfg_we                i_cfg_idx (0 range limit, 1 budget reload),
//                                   i_cfg_data
//
// Every request except a poll is done at once: its result strobes in
// the next cycle and busy never rises, so requests may follow back to back.
// A poll walks the frame store one byte a cycle through a single read port
// and then the level slots one a cycle; its longest walk is a resync over
// a full frame plus a full slot scan.
// Reset (i_rst_n low, synchronous) brings back the reset mode, budget,
// configuration registers and empty level slots at once; no clearing pass.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module laser_range_frame_collector_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [lrfc_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [lrfc_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic [lrfc_pkg::SLOT_IDX_W-1:0] i_slot_index,
    // configuration write
    input  logic                            i_cfg_we,
    input  logic [lrfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lrfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // result
    output logic                            o_valid,
    output logic [lrfc_pkg::MODE_W-1:0]     o_mode,
    output logic [lrfc_pkg::SEND_W-1:0]     o_send_command,
    output logic [lrfc_pkg::STATUS_W-1:0]   o_parse_status,
    output logic [lrfc_pkg::DIST_W-1:0]     o_distance_value,
    output logic                            o_slot_written,
    output logic [lrfc_pkg::SLOT_IDX_W-1:0] o_slot_number,
    output logic [lrfc_pkg::LEVEL_W-1:0]    o_level_value
);

    // Sequencer command and datapath flags
    lrfc_pkg::t_dp_op  dp_op;
    lrfc_pkg::t_dp_sts dp_sts;

    // Sequencer: one state per parse step (header, sync byte, resync
    // search, distance gather, range check, slot scan, finish).
    lrfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (dp_sts),
        .o_op     (dp_op),
        .busy     (busy)
    );

    // Datapath: frame store, level slots, mode/budget and result registers.
    lrfc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (dp_op),
        .o_sts            (dp_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_rx_byte        (i_rx_byte),
        .i_slot_index     (i_slot_index),
        .o_valid          (o_valid),
        .o_mode           (o_mode),
        .o_send_command   (o_send_command),
        .o_parse_status   (o_parse_status),
        .o_distance_value (o_distance_value),
        .o_slot_written   (o_slot_written),
        .o_slot_number    (o_slot_number),
        .o_level_value    (o_level_value)
    );

endmodule

### rtl/lrfc_chk.sv
module lrfc_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [lrfc_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic                            o_valid,
    input  logic [lrfc_pkg::MODE_W-1:0]     o_mode,
    input  logic [lrfc_pkg::SEND_W-1:0]     o_send_command,
    input  logic [lrfc_pkg::STATUS_W-1:0]   o_parse_status,
    input  logic                            o_slot_written
);

    // A result never appears while a poll is still being worked on
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Non-poll requests answer in the next cycle
    a_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode != lrfc_pkg::OP_POLL)) |=> o_valid)
        else $error("missing result for single-cycle request");

    // No result without a request or a finishing poll
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start) || $past(busy)))
        else $error("result without request");

    // A command goes out only in the mode that asks for it
    a_send_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_send_command != lrfc_pkg::SEND_NONE)) |->
        ((o_send_command == lrfc_pkg::SEND_GET_DIST && o_mode == lrfc_pkg::MODE_READ) ||
         (o_send_command == lrfc_pkg::SEND_POWER_ON && o_mode == lrfc_pkg::MODE_ON)))
        else $error("command does not match mode");

    // A written slot implies a good parse
    a_slot_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_slot_written) |-> (o_parse_status == lrfc_pkg::ST_OK))
        else $error("slot written without good parse");

endmodule

bind laser_range_frame_collector_core lrfc_chk u_lrfc_chk (.*);
